// ===== rtl/core/swct_pkg.sv =====
// Package for the sorted word count table: sizes, codes and payload types.
// Used by the top level and swct_engine under rtl/core; depends on nothing.
`default_nettype none

package swct_pkg;

   // Table geometry
   localparam int CAPACITY   = 1024;
   localparam int COUNT_BITS = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int TOT_W      = $clog2(CAPACITY + 1);

   // Fixed field widths of the channels
   localparam int PART_W = 64;
   localparam int WORD_W = 4 * PART_W;
   localparam int POS_W  = 10;
   localparam int OCC_W  = 32;
   localparam int USED_W = 11;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Request function codes
   localparam logic FUNC_COUNT = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_BEYOND   = 2'd3;

   typedef struct packed {
      logic              func;
      logic [PART_W-1:0] word_part0;
      logic [PART_W-1:0] word_part1;
      logic [PART_W-1:0] word_part2;
      logic [PART_W-1:0] word_part3;
      logic [POS_W-1:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [POS_W-1:0]  position;
      logic [OCC_W-1:0]  occurrences;
      logic [PART_W-1:0] out_part0;
      logic [PART_W-1:0] out_part1;
      logic [PART_W-1:0] out_part2;
      logic [PART_W-1:0] out_part3;
      logic [USED_W-1:0] entries_used;
   } rsp_type;

   // Shared address and write-enable bundle for the word and count memories
   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic [IDX_W-1:0] wr_addr;
      logic             word_we;
      logic             count_we;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_word_count_table_unit.sv =====
// Sorted word count table, top level: both table memories, the sequencer
// and the result register. Depends on swct_pkg, swct_ram and swct_engine.
//
// Usage:
//  - req_ channel: one transfer carries a count item (func = count) with a
//    256-bit word in four parts, or a read item (func = read) with an index.
//  - rsp_ channel: exactly one result transfer per request, in order.
//  - Count item: binary search over the sorted table, a search state and a
//    compare state per probe, at most 11 probes. A match bumps the saturating
//    count in place. A new word shifts every later entry up one place, one
//    entry per cycle through the memory port, then is written at the search's
//    low bound.
//  - Read item: one memory read; an index beyond the entry count needs none.
//  - The rate is set by the single read and write port of each memory.
//  - One item at a time is in flight; a new request is taken as soon as the
//    previous result sits in the output register, even if rsp_ready is low.
//  - A stalled receiver holds the result register; the sequencer then parks
//    its finished result until the register frees up.
//  - Reset empties the table at once (entry count to zero); memory contents
//    are left as is and are never read before being written.
`default_nettype none

module sorted_word_count_table_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire swct_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output swct_pkg::rsp_type      rsp_data
);
   import swct_pkg::*;

   mem_ctl_type           mem_ctl;
   logic [WORD_W-1:0]     word_wdata, word_rdata;
   logic [COUNT_BITS-1:0] count_wdata, count_rdata;
   logic                  res_valid, res_take;
   rsp_type               res_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // word store: one 256-bit row per entry, part 0 in the top bits
   swct_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_word_ram (
      .clock (clock),
      .we    (mem_ctl.word_we),
      .waddr (mem_ctl.wr_addr),
      .wdata (word_wdata),
      .raddr (mem_ctl.rd_addr),
      .rdata (word_rdata)
   );

   swct_ram #(.WIDTH(COUNT_BITS), .DEPTH(CAPACITY)) u_count_ram (
      .clock (clock),
      .we    (mem_ctl.count_we),
      .waddr (mem_ctl.wr_addr),
      .wdata (count_wdata),
      .raddr (mem_ctl.rd_addr),
      .rdata (count_rdata)
   );

   swct_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .mem_ctl     (mem_ctl),
      .word_wdata  (word_wdata),
      .count_wdata (count_wdata),
      .word_rdata  (word_rdata),
      .count_rdata (count_rdata),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .res_take    (res_take)
   );

   // result register: reload when empty or when the current transfer completes
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // one item in flight: the sequencer is busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous item still in progress");

   // a fresh entry always starts with a count of one
   a_insert_count_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_INSERTED) |-> (rsp_data.occurrences == OCC_W'(1)))
      else $error("inserted entry without count of one");

   // entry count never passes the table size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entries_used <= USED_W'(CAPACITY)))
      else $error("entry count beyond capacity");

   // a table-full result is only possible with every entry in use
   a_full_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL)
         |-> (rsp_data.entries_used == USED_W'(CAPACITY)))
      else $error("full reported on a table with free entries");

endmodule

`default_nettype wire

// ===== rtl/core/swct_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`default_nettype none

module swct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/swct_engine.sv =====
// Sequencer of the sorted word count table: binary search, shift-up insert,
// count update and indexed read over the two memories. Uses swct_pkg.
`default_nettype none

module swct_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire swct_pkg::req_type              req_data,
   output swct_pkg::mem_ctl_type               mem_ctl,
   output logic [swct_pkg::WORD_W-1:0]         word_wdata,
   output logic [swct_pkg::COUNT_BITS-1:0]     count_wdata,
   input  wire logic [swct_pkg::WORD_W-1:0]    word_rdata,
   input  wire logic [swct_pkg::COUNT_BITS-1:0] count_rdata,
   output logic                                res_valid,
   output swct_pkg::rsp_type                   res_data,
   input  wire logic                           res_take
);
   import swct_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SEARCH    = 3'd1;
   localparam logic [2:0] S_CMP       = 3'd2;
   localparam logic [2:0] S_SHIFT     = 3'd3;
   localparam logic [2:0] S_READ_DATA = 3'd4;
   localparam logic [2:0] S_DONE      = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [TOT_W-1:0]  lo_ff, lo_in;
   logic [TOT_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic [TOT_W-1:0]  ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   rsp_type           res_ff, res_in;

   logic [TOT_W-1:0]      mid_full;
   logic [COUNT_BITS-1:0] count_next;
   logic                  accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

   assign mid_full   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign count_next = (count_rdata == COUNT_MAX) ? count_rdata
                                                  : count_rdata + COUNT_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      total_in     = total_ff;
      res_in       = res_ff;
      mem_ctl      = '0;
      word_wdata   = word_rdata;
      count_wdata  = count_rdata;

      // a shift copy fetched last cycle lands one place higher
      if (pend_ff) begin
         mem_ctl.wr_addr  = pend_addr_ff;
         mem_ctl.word_we  = 1'b1;
         mem_ctl.count_we = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            mem_ctl.rd_addr = IDX_W'(req_data.read_index);
            if (accept) begin
               word_in = {req_data.word_part0, req_data.word_part1,
                          req_data.word_part2, req_data.word_part3};
               idx_in  = IDX_W'(req_data.read_index);
               lo_in   = '0;
               hi_in   = total_ff;
               if (req_data.func == FUNC_READ) begin
                  if (TOT_W'(req_data.read_index) >= total_ff) begin
                     res_in              = '0;
                     res_in.status       = ST_BEYOND;
                     res_in.position     = req_data.read_index;
                     res_in.entries_used = USED_W'(total_ff);
                     state_in            = S_DONE;
                  end else begin
                     state_in = S_READ_DATA;
                  end
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_READ_DATA: begin
            res_in.status       = ST_FOUND;
            res_in.position     = POS_W'(idx_ff);
            res_in.occurrences  = OCC_W'(count_rdata);
            res_in.out_part0    = word_rdata[4*PART_W-1:3*PART_W];
            res_in.out_part1    = word_rdata[3*PART_W-1:2*PART_W];
            res_in.out_part2    = word_rdata[2*PART_W-1:PART_W];
            res_in.out_part3    = word_rdata[PART_W-1:0];
            res_in.entries_used = USED_W'(total_ff);
            state_in            = S_DONE;
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mem_ctl.rd_addr = mid_full[IDX_W-1:0];
               mid_in          = mid_full[IDX_W-1:0];
               state_in        = S_CMP;
            end else if (total_ff == TOT_W'(CAPACITY)) begin
               res_in              = '0;
               res_in.status       = ST_FULL;
               res_in.entries_used = USED_W'(total_ff);
               state_in            = S_DONE;
            end else begin
               ptr_in   = total_ff;
               pend_in  = 1'b0;
               state_in = S_SHIFT;
            end
         end
         S_CMP: begin
            if (word_ff == word_rdata) begin
               mem_ctl.wr_addr     = mid_ff;
               mem_ctl.count_we    = 1'b1;
               count_wdata         = count_next;
               res_in              = '0;
               res_in.status       = ST_FOUND;
               res_in.position     = POS_W'(mid_ff);
               res_in.occurrences  = OCC_W'(count_next);
               res_in.entries_used = USED_W'(total_ff);
               state_in            = S_DONE;
            end else if (word_ff < word_rdata) begin
               hi_in    = TOT_W'(mid_ff);
               state_in = S_SEARCH;
            end else begin
               lo_in    = TOT_W'(mid_ff) + TOT_W'(1);
               state_in = S_SEARCH;
            end
         end
         S_SHIFT: begin
            if (ptr_ff > lo_ff) begin
               mem_ctl.rd_addr = IDX_W'(ptr_ff - TOT_W'(1));
               pend_in         = 1'b1;
               pend_addr_in    = ptr_ff[IDX_W-1:0];
               ptr_in          = ptr_ff - TOT_W'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               // gap is open at the low bound: drop the new word in
               mem_ctl.wr_addr     = lo_ff[IDX_W-1:0];
               mem_ctl.word_we     = 1'b1;
               mem_ctl.count_we    = 1'b1;
               word_wdata          = word_ff;
               count_wdata         = COUNT_BITS'(1);
               total_in            = total_ff + TOT_W'(1);
               res_in              = '0;
               res_in.status       = ST_INSERTED;
               res_in.position     = POS_W'(lo_ff);
               res_in.occurrences  = OCC_W'(1);
               res_in.entries_used = USED_W'(total_ff + TOT_W'(1));
               state_in            = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      idx_ff       <= idx_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      ptr_ff       <= ptr_in;
      pend_addr_ff <= pend_addr_in;
      res_ff       <= res_in;
   end

endmodule

`default_nettype wire
